[sv/pse_pkg.sv]
package pse_pkg;

  // Printable character range and line end characters
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;

  // Width of the threshold register
  localparam int unsigned MIN_LEN_W = 6;

  // Source select for the output register
  localparam logic [1:0] OSEL_MEM = 2'd0;
  localparam logic [1:0] OSEL_CR  = 2'd1;
  localparam logic [1:0] OSEL_LF  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       store_wr;  // write the input byte at the fill position
    logic       pend_wr;   // write the latched byte at entry zero
    logic       clr;       // close the run and empty the buffer
    logic       latch_in;  // capture the input byte and final flag
    logic       idx_clr;   // restart the read-out index
    logic       idx_inc;   // step the read-out index
    logic       rd_en;     // read the buffer at the read-out index
    logic       out_load;  // load the output register
    logic [1:0] out_sel;   // what the output register is loaded with
    logic       out_last;  // last result of this input byte
  } pse_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic printable;  // input byte is printable
    logic in_fin;     // input byte marks the end of the dump
    logic full;       // buffer holds a whole chunk
    logic in_run;     // a run is open
    logic tail_long;  // held count exceeds the threshold
    logic last_idx;   // read-out index is at the last held byte
    logic out_free;   // output register can take a result this cycle
    logic pend_fin;   // latched byte marked the end of the dump
  } pse_sts_t;

endpackage

[sv/pse_ctrl.sv]
module pse_ctrl
  import pse_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pse_sts_t sts,
  output pse_cmd_t cmd
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_CR   = 3'd3;
  localparam logic [2:0] S_LF   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       chunk_r;   // flush of a full chunk, no line end
  logic       chunk_nxt;

  // State and mode registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chunk_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chunk_r <= chunk_nxt;
    end
  end

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    chunk_nxt = chunk_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (sts.printable) begin
            if (sts.full) begin
              // Buffer full: flush it, keep this byte for the new chunk
              cmd.latch_in = 1'b1;
              cmd.idx_clr  = 1'b1;
              chunk_nxt    = 1'b1;
              state_nxt    = S_READ;
            end else begin
              cmd.store_wr = 1'b1;
              cmd.clr      = sts.in_fin;
            end
          end else if (sts.in_run) begin
            if (sts.tail_long) begin
              cmd.latch_in = 1'b1;
              cmd.idx_clr  = 1'b1;
              chunk_nxt    = 1'b0;
              state_nxt    = S_READ;
            end else begin
              cmd.clr = 1'b1;
            end
          end else begin
            cmd.clr = sts.in_fin;
          end
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_MEM;
          cmd.out_last = sts.last_idx & chunk_r;
          cmd.idx_inc  = 1'b1;
          if (sts.last_idx) begin
            if (chunk_r) begin
              // Start the new chunk with the byte that found the buffer full
              cmd.pend_wr = 1'b1;
              cmd.clr     = sts.pend_fin;
              state_nxt   = S_IDLE;
            end else begin
              state_nxt = S_CR;
            end
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_CR: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_CR;
          state_nxt    = S_LF;
        end
      end
      S_LF: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_LF;
          cmd.out_last = 1'b1;
          cmd.clr      = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[sv/pse_datapath.sv]
module pse_datapath
  import pse_pkg::*;
#(
  parameter int unsigned CHUNK_LEN = 49
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_data,
  input  logic                 in_fin,
  input  logic [MIN_LEN_W-1:0] min_len,
  input  pse_cmd_t             cmd,
  output pse_sts_t             sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_data,
  output logic                 out_last
);

  localparam int unsigned AW   = (CHUNK_LEN > 1) ? $clog2(CHUNK_LEN) : 1;
  localparam int unsigned CW   = $clog2(CHUNK_LEN + 1);
  localparam int unsigned CMPW = (CW > MIN_LEN_W) ? CW : MIN_LEN_W;

  logic [7:0]    buf_mem [CHUNK_LEN];
  logic [7:0]    rd_data_r;
  logic [CW-1:0] held_cnt_r;
  logic          in_run_r;
  logic [AW-1:0] rd_idx_r;
  logic [7:0]    pend_byte_r;
  logic          pend_fin_r;
  logic          out_valid_r;
  logic [7:0]    out_data_r;
  logic          out_last_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [7:0]    out_data_nxt;

  // Buffer write port: fill position, or entry zero for a held-over byte
  assign mem_we    = cmd.store_wr | cmd.pend_wr;
  assign mem_waddr = cmd.store_wr ? held_cnt_r[AW-1:0] : '0;
  assign mem_wdata = cmd.store_wr ? in_data : pend_byte_r;

  // Buffer memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      buf_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      rd_data_r <= buf_mem[rd_idx_r];
    end
  end

  // Held count and run flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= '0;
      in_run_r   <= 1'b0;
    end else if (cmd.clr) begin
      held_cnt_r <= '0;
      in_run_r   <= 1'b0;
    end else if (cmd.store_wr) begin
      held_cnt_r <= held_cnt_r + CW'(1);
      in_run_r   <= 1'b1;
    end else if (cmd.pend_wr) begin
      held_cnt_r <= CW'(1);
      in_run_r   <= 1'b1;
    end
  end

  // Read-out index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
    end else if (cmd.idx_clr) begin
      rd_idx_r <= '0;
    end else if (cmd.idx_inc) begin
      rd_idx_r <= rd_idx_r + AW'(1);
    end
  end

  // Latched input byte kept across a flush
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      pend_byte_r <= in_data;
      pend_fin_r  <= in_fin;
    end
  end

  // Output source select
  always_comb begin
    case (cmd.out_sel)
      OSEL_MEM: out_data_nxt = rd_data_r;
      OSEL_CR:  out_data_nxt = CH_CR;
      OSEL_LF:  out_data_nxt = CH_LF;
      default:  out_data_nxt = rd_data_r;
    endcase
  end

  // Output register, freed by a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
      out_last_r <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

  // Status towards the controller
  assign sts.printable = (in_data >= PRINT_LO) && (in_data <= PRINT_HI);
  assign sts.in_fin    = in_fin;
  assign sts.full      = (held_cnt_r == CW'(CHUNK_LEN));
  assign sts.in_run    = in_run_r;
  assign sts.tail_long = (CMPW'(held_cnt_r) > CMPW'(min_len));
  assign sts.last_idx  = (CW'(rd_idx_r) == (held_cnt_r - CW'(1)));
  assign sts.out_free  = ~out_valid_r | out_ready;
  assign sts.pend_fin  = pend_fin_r;

endmodule

[sv/printable_string_extractor_top.sv]
// Channel  Direction  tdata          tuser / tlast
// in_      slave      data_byte[7:0] tlast = final_byte
// out_     master     out_char[7:0]  tlast = last_of_burst
// cfg_     APB slave  register 0 at byte address 0: min_len_exclusive[5:0]
//
// A byte that flushes held bytes is taken first; each held byte then passes the read
// and load states in turn, and CR and LF follow at the end of a run; the
// single registered read port of the chunk buffer sets this.
// Reset clears the held count and run flag and sets the threshold to 10; the
// buffer contents are not cleared. A stalled output holds the sequencer in place.
module printable_string_extractor_top
  import pse_pkg::*;
#(
  parameter int unsigned CHUNK_LEN = 49
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_char
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST = MIN_LEN_W'(10);

  logic [MIN_LEN_W-1:0] min_len_r;
  logic                 cfg_wr;
  pse_cmd_t             cmd;
  pse_sts_t             sts;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready & ~cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RST;
    end else if (cfg_wr) begin
      min_len_r <= cfg_pwdata[MIN_LEN_W-1:0];
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {{(32 - MIN_LEN_W){1'b0}}, min_len_r};

  // Sequencer
  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Chunk buffer, counters and output register
  pse_datapath #(
    .CHUNK_LEN (CHUNK_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .in_fin    (in_tlast),
    .min_len   (min_len_r),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule
